[design/pfsd_pkg.sv]
// Shared types, sizes and arithmetic helpers for the palette dither unit.
// No dependencies; imported by the unit's RTL.
`default_nettype none

package pfsd_pkg;

	localparam int MAX_WIDTH     = 4096;
	localparam int PALETTE_DEPTH = 256;

	localparam int ROW_AW  = $clog2(MAX_WIDTH);
	localparam int FILL_W  = ROW_AW + 1;
	localparam int PAL_AW  = $clog2(PALETTE_DEPTH);
	localparam int DIST_W  = 18;

	// colour as 0xRRGGBB: element 0 is red
	typedef logic [0:2][7:0] rgb_t;
	// three signed 9-bit errors, red in the top field
	typedef logic [0:2][8:0] err_t;

	// diffusion weights in order: above-left, above, above-right, left
	localparam logic [3:0] DIFF_WEIGHT [4] = '{4'd1, 4'd5, 4'd3, 4'd7};

	// c + floor(e * w / 16), clamped to 0..255
	function automatic logic [7:0] diffuse(input logic [7:0] c, input logic [8:0] e,
			input logic [3:0] w);
		logic signed [12:0] prod;
		logic signed [12:0] sum;
		logic [7:0]         res;
		prod = $signed({{4{e[8]}}, e}) * $signed({9'd0, w});
		sum  = $signed({5'd0, c}) + (prod >>> 4);
		if (sum < 13'sd0) begin
			res = 8'd0;
		end else if (sum > 13'sd255) begin
			res = 8'd255;
		end else begin
			res = sum[7:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

[design/palette_floyd_steinberg_dither_unit.sv]
// Top level of the palette dither unit: error diffusion, nearest-colour search.
// Depends on pfsd_pkg (sizes, types, diffuse()).
`default_nettype none

// Floyd-Steinberg dither onto a loadable palette of up to 256 colours.
// A request with mode=1 loads one palette slot, leaves the unit ready and
// returns no result. A request with mode=0 is a raster-order pixel: it
// picks up the diffused error of its neighbours (above-left x1, above x5,
// above-right x3, left x7, each /16 with floor and clamped to 0..255 in turn),
// is matched to the nearest active palette entry by squared RGB distance
// (ties to the lowest index) and returns the chosen colour and its index.
// A pixel occupies the unit through error taps read in turn through the single
// row-store read port, a search of one palette entry per cycle through the
// shared distance unit, a drain of its pipeline and a write-back that waits for
// room in the output register (with a second write-back on the last column of
// a row). in_ready is low meanwhile; the result sits in an output register so
// the next request can be taken while it waits. frame_start on a pixel discards
// all row errors; the row store is tracked by a fill mark, so no clearing pass is needed.
// Configure image_width and palette_size only while the unit is idle, and
// load every palette slot below palette_size before dithering.

module palette_floyd_steinberg_dither_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_index,
	input  wire logic [12:0] cfg_data,
	// request channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        mode,
	input  wire logic        frame_start,
	input  wire logic [7:0]  pixel_red,
	input  wire logic [7:0]  pixel_green,
	input  wire logic [7:0]  pixel_blue,
	input  wire logic [7:0]  entry_index,
	input  wire logic [23:0] entry_color,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_red,
	output logic [7:0]       out_green,
	output logic [7:0]       out_blue,
	output logic [7:0]       color_index
);

	import pfsd_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIFF  = 3'd1;
	localparam logic [2:0] ST_SRCH  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_ERR   = 3'd4;
	localparam logic [2:0] ST_WBL   = 3'd5;

	localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [0:0] REG_PALETTE_SIZE = 1'b1;

	// config registers
	logic [12:0] image_width_q;
	logic [8:0]  palette_size_q;
	logic [12:0] w_eff;
	logic [8:0]  n_eff;

	// sequencer
	logic [2:0]        state_q;
	logic [2:0]        step_q;
	logic [PAL_AW-1:0] k_q;

	// per-pixel context
	logic [ROW_AW-1:0] x_q;
	logic              last_q;
	rgb_t              adj_q;
	err_t              left_err_q;
	logic [ROW_AW-1:0] col_q;
	logic [FILL_W-1:0] fill_q;

	// row error store
	err_t              row_mem [MAX_WIDTH];
	err_t              row_rd_s1;
	logic              tap_ok_s1;
	logic [ROW_AW-1:0] row_raddr;
	logic              tap_ok_d;
	logic              row_we;
	logic [ROW_AW-1:0] row_waddr;
	err_t              row_wdata;

	// palette store and search pipeline
	rgb_t              pal_mem [PALETTE_DEPTH];
	logic              pal_we;
	rgb_t              pal_rd_s1;
	logic [PAL_AW-1:0] idx_s1;
	logic              v_s1;
	logic [DIST_W-1:0] dist_s2;
	rgb_t              col_s2;
	logic [PAL_AW-1:0] idx_s2;
	logic              v_s2;
	logic [DIST_W-1:0] best_dist_q;
	rgb_t              best_color_q;
	logic [PAL_AW-1:0] best_idx_q;
	logic [DIST_W-1:0] dist_d;

	// diffusion unit
	err_t       tap_err;
	logic [3:0] tap_w;
	rgb_t       adj_d;

	// pixel entry
	logic              px_take;
	logic [ROW_AW-1:0] col_eff;
	logic [ROW_AW-1:0] x_d;
	err_t              pe;
	logic              err_fire;

	// output register
	logic              out_valid_q;
	rgb_t              out_color_q;
	logic [7:0]        out_idx_q;

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign out_red     = out_color_q[0];
	assign out_green   = out_color_q[1];
	assign out_blue    = out_color_q[2];
	assign color_index = out_idx_q;

	always_comb begin
		if (image_width_q < 13'd2) begin
			w_eff = 13'd2;
		end else if (image_width_q > 13'(MAX_WIDTH)) begin
			w_eff = 13'(MAX_WIDTH);
		end else begin
			w_eff = image_width_q;
		end
		if (palette_size_q == 9'd0) begin
			n_eff = 9'd1;
		end else if (palette_size_q > 9'(PALETTE_DEPTH)) begin
			n_eff = 9'(PALETTE_DEPTH);
		end else begin
			n_eff = palette_size_q;
		end
	end

	// column of an arriving pixel; a shrunk width restarts the row
	assign px_take = in_valid && in_ready && !mode;
	assign col_eff = frame_start ? '0 : col_q;
	assign x_d     = ({1'b0, col_eff} >= w_eff) ? '0 : col_eff;

	// taps x-1, x, x+1 are read on steps 0..2; beyond the fill mark reads as zero
	assign row_raddr = x_q + ROW_AW'(step_q) - ROW_AW'(1);
	assign tap_ok_d  = ({1'b0, row_raddr} < fill_q)
	                 && !(step_q == 3'd0 && x_q == '0)
	                 && !(step_q == 3'd2 && last_q);

	// shared diffusion step: one tap on all three channels per cycle
	always_comb begin
		tap_w = DIFF_WEIGHT[2'(step_q - 3'd1)];
		if (step_q == 3'd4) begin
			tap_err = (x_q != '0) ? left_err_q : '0;
		end else begin
			tap_err = tap_ok_s1 ? row_rd_s1 : '0;
		end
		for (int ch = 0; ch < 3; ch++) begin
			adj_d[ch] = diffuse(adj_q[ch], tap_err[ch], tap_w);
		end
	end

	// squared distance of the entry read last cycle
	always_comb begin
		logic signed [8:0]  diff;
		logic signed [17:0] sq;
		dist_d = '0;
		for (int ch = 0; ch < 3; ch++) begin
			diff   = $signed({1'b0, adj_q[ch]}) - $signed({1'b0, pal_rd_s1[ch]});
			sq     = diff * diff;
			dist_d = dist_d + DIST_W'($unsigned(sq));
		end
	end

	// quantisation error of the chosen colour
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			pe[ch] = {1'b0, adj_q[ch]} - {1'b0, best_color_q[ch]};
		end
	end

	assign err_fire = (state_q == ST_ERR) && (!out_valid_q || out_ready);

	// row store write-back: left neighbour's error, then on the last column our own
	always_comb begin
		row_we    = 1'b0;
		row_waddr = x_q;
		row_wdata = left_err_q;
		if (err_fire && x_q != '0) begin
			row_we    = 1'b1;
			row_waddr = x_q - ROW_AW'(1);
		end else if (state_q == ST_WBL) begin
			row_we    = 1'b1;
		end
	end

	assign pal_we = in_valid && in_ready && mode
	             && ({1'b0, entry_index} < 9'(PALETTE_DEPTH));

	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[entry_index[PAL_AW-1:0]] <= entry_color;
		end
		pal_rd_s1 <= pal_mem[k_q];
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_waddr] <= row_wdata;
		end
		row_rd_s1 <= row_mem[row_raddr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		tap_ok_s1 <= tap_ok_d;
		idx_s1    <= k_q;
		dist_s2   <= dist_d;
		col_s2    <= pal_rd_s1;
		idx_s2    <= idx_s1;
		if (px_take) begin
			adj_q  <= {pixel_red, pixel_green, pixel_blue};
			x_q    <= x_d;
			last_q <= ({1'b0, x_d} == w_eff - 13'd1);
		end else if (state_q == ST_DIFF && step_q != 3'd0) begin
			adj_q <= adj_d;
		end
		if (state_q == ST_DIFF && step_q == 3'd4) begin
			best_dist_q <= '1;
		end else if (v_s2 && dist_s2 < best_dist_q) begin
			best_dist_q  <= dist_s2;
			best_color_q <= col_s2;
			best_idx_q   <= idx_s2;
		end
		if (err_fire) begin
			out_color_q <= best_color_q;
			out_idx_q   <= 8'(best_idx_q);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 13'd640;
			palette_size_q <= 9'd1;
			state_q        <= ST_IDLE;
			step_q         <= '0;
			k_q            <= '0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			left_err_q     <= '0;
			col_q          <= '0;
			fill_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
					REG_PALETTE_SIZE: palette_size_q <= cfg_data[8:0];
					default: ;
				endcase
			end

			v_s1 <= (state_q == ST_SRCH);
			v_s2 <= v_s1;

			// a new result replaces one leaving in the same cycle
			if (err_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (row_we && {1'b0, row_waddr} >= fill_q) begin
				fill_q <= FILL_W'(row_waddr) + FILL_W'(1);
			end

			unique case (state_q)
				ST_IDLE: begin
					if (px_take) begin
						if (frame_start) begin
							fill_q     <= '0;
							left_err_q <= '0;
						end
						step_q  <= '0;
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4) begin
						k_q     <= '0;
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					k_q <= k_q + PAL_AW'(1);
					if (9'(k_q) == n_eff - 9'd1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					if (err_fire) begin
						left_err_q  <= pe;
						col_q       <= last_q ? '0 : x_q + ROW_AW'(1);
						state_q     <= last_q ? ST_WBL : ST_IDLE;
					end
				end
				ST_WBL: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[design/pfsd_checker.sv]
// Port-level checks for the palette dither unit, bound to its top level.
// Depends only on the top level's port names.
`default_nettype none

module pfsd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       mode,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_red,
	input wire logic [7:0] out_green,
	input wire logic [7:0] out_blue,
	input wire logic [7:0] color_index
);

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({out_red, out_green, out_blue, color_index}))
		else $error("result changed while stalled");

	// a pixel request makes the unit busy
	a_px_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !mode |=> !in_ready)
		else $error("ready straight after a pixel request");

	// a pixel result cannot appear the cycle after it is taken
	a_px_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !mode |=> !$rose(out_valid))
		else $error("pixel result too early");

	// palette loads never stall the request side
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode |=> in_ready)
		else $error("palette load left the unit busy");

endmodule

bind palette_floyd_steinberg_dither_unit pfsd_checker u_pfsd_checker (.*);

`default_nettype wire
